// ===== rtl/core/utf8_to_codepoint_stream_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODEPOINT_STREAM_DECODER_MACROS_SVH
`define UTF8_TO_CODEPOINT_STREAM_DECODER_MACROS_SVH

// Check an implication or expression on every clock outside reset.
`define U8D_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("u8d assertion failed");

// Check that a condition in one cycle leads to another in the next.
`define U8D_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("u8d sequencing assertion failed");

`endif

// ===== rtl/core/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Types, constants and decode functions shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

  localparam int unsigned HeldDepth = 3;
  localparam int unsigned BufDepth  = HeldDepth + 1;

  localparam logic [2:0] LenInvalid = 3'd0;

  typedef logic [BufDepth-1:0][7:0] buf_t;

  typedef struct packed {
    logic       valid;
    buf_t       bytes;
    logic [2:0] count;
  } batch_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        invalid;
    logic [2:0]  used;
  } dec_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = LenInvalid;
    if (!b[7]) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic dec_t decode(input buf_t b, input logic [2:0] cap);
    dec_t       r;
    logic [2:0] len;
    len       = lead_len(b[0]);
    r.cp      = '0;
    r.invalid = 1'b1;
    r.used    = 3'd1;
    if (len != LenInvalid && len <= cap) begin
      r.invalid = 1'b0;
      r.used    = len;
      case (len)
        3'd1:    r.cp = {14'd0, b[0][6:0]};
        3'd2:    r.cp = {10'd0, b[0][4:0], b[1][5:0]};
        3'd3:    r.cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
        3'd4:    r.cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
        default: r.cp = '0;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/u8d_assemble.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder byte assembler
// Holds the bytes of an open sequence and releases a batch when it is
// complete, the lead byte is not a multi-byte lead, or the string ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_to_codepoint_stream_decoder_macros.svh"

module u8d_assemble
  import u8d_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       end_i,
  output logic            byte_ready_o,
  output batch_t          batch_o,
  input  wire logic       batch_ready_i
);

  logic [HeldDepth-1:0][7:0] held_q;
  logic [1:0]                held_cnt_q, held_cnt_d;
  logic [2:0]                need_q, need_d;

  buf_t       buf_w;
  logic [2:0] n_w;
  logic [2:0] lead_w;
  logic       done_w;
  logic       accept_w;

  always_comb begin
    for (int i = 0; i < HeldDepth; i++) begin
      buf_w[i] = (held_cnt_q == 2'(i)) ? byte_i : held_q[i];
    end
    buf_w[HeldDepth] = byte_i;
    n_w    = {1'b0, held_cnt_q} + 3'd1;
    lead_w = lead_len(byte_i);
    if (held_cnt_q == 2'd0) begin
      done_w = end_i || lead_w <= 3'd1;
    end else begin
      done_w = end_i || n_w >= need_q;
    end
  end

  assign byte_ready_o = batch_ready_i;
  assign accept_w     = byte_valid_i && byte_ready_o;

  assign batch_o.valid = accept_w && done_w;
  assign batch_o.bytes = buf_w;
  assign batch_o.count = n_w;

  always_comb begin
    held_cnt_d = held_cnt_q;
    need_d     = need_q;
    if (accept_w) begin
      if (done_w) begin
        held_cnt_d = '0;
        need_d     = LenInvalid;
      end else begin
        held_cnt_d = n_w[1:0];
        need_d     = (held_cnt_q == 2'd0) ? lead_w : need_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= '0;
      need_q     <= LenInvalid;
    end else begin
      held_cnt_q <= held_cnt_d;
      need_q     <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w && !done_w && held_cnt_q != 2'd3) begin
      held_q[held_cnt_q] <= byte_i;
    end
  end

  `U8D_ASSERT(a_held_below_need, clk_i, rst_ni,
              held_cnt_q != 2'd0 |-> {1'b0, held_cnt_q} < need_q)
  `U8D_ASSERT(a_need_clear_when_empty, clk_i, rst_ni,
              held_cnt_q == 2'd0 |-> need_q == LenInvalid)
  `U8D_ASSERT_NEXT(a_hold_grows, clk_i, rst_ni, accept_w && !done_w, held_cnt_q != 2'd0)

endmodule

`default_nettype wire

// ===== rtl/core/u8d_emit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder result emitter
// Decodes one code point per cycle, while the output register is free, from
// the current batch into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_to_codepoint_stream_decoder_macros.svh"

module u8d_emit
  import u8d_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire batch_t  batch_i,
  output logic         batch_ready_o,
  output logic         res_valid_o,
  output logic [20:0]  res_cp_o,
  output logic         res_invalid_o,
  output logic [2:0]   res_used_o,
  output logic         res_last_o,
  input  wire logic    res_ready_i
);

  logic        bat_valid_q;
  buf_t        bytes_q;
  logic [2:0]  rem_q;

  logic        out_valid_q;
  logic [20:0] cp_q;
  logic        inv_q;
  logic [2:0]  used_q;
  logic        last_q;

  dec_t        res_w;
  logic        out_free_w;
  logic        emit_w;
  logic        last_w;

  assign res_w         = decode(bytes_q, rem_q);
  assign out_free_w    = !out_valid_q || res_ready_i;
  assign emit_w        = bat_valid_q && out_free_w;
  assign last_w        = res_w.used >= rem_q;
  assign batch_ready_o = !bat_valid_q || (emit_w && last_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bat_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (batch_ready_o) begin
        bat_valid_q <= batch_i.valid;
      end
      if (emit_w) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_ready_o && batch_i.valid) begin
      bytes_q <= batch_i.bytes;
      rem_q   <= batch_i.count;
    end else if (emit_w) begin
      bytes_q <= bytes_q >> {res_w.used, 3'b000};
      rem_q   <= rem_q - res_w.used;
    end
    if (emit_w) begin
      cp_q   <= res_w.cp;
      inv_q  <= res_w.invalid;
      used_q <= res_w.used;
      last_q <= last_w;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign res_cp_o      = cp_q;
  assign res_invalid_o = inv_q;
  assign res_used_o    = used_q;
  assign res_last_o    = last_q;

  `U8D_ASSERT(a_rem_in_range, clk_i, rst_ni,
              bat_valid_q |-> rem_q != 3'd0 && rem_q <= 3'd4)
  `U8D_ASSERT(a_invalid_shape, clk_i, rst_ni,
              out_valid_q && inv_q |-> cp_q == 21'd0 && used_q == 3'd1)
  `U8D_ASSERT_NEXT(a_batch_continues, clk_i, rst_ni, emit_w && !last_w, bat_valid_q)

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_codepoint_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to code point stream decoder
// Turns a byte stream of UTF-8 strings into a stream of code points.
// ----------------------------------------------------------------------------
// Slave channel: one byte per request, tlast on the final byte of a string.
// Master channel: one code point per request; tuser flags a bad lead byte or
// a sequence cut short by the end of the string; tlast marks the final
// result caused by one input byte.
// Bytes of an open multi-byte sequence are held and give no result until
// the sequence completes or the string ends.
// The completing byte's batch is registered in the emitter, then decoded into the output register.
// Rate: one byte per cycle while each byte gives at most one result and the receiver does not stall.
// A string that ends inside a sequence gives up to three results, one per
// cycle while the receiver accepts them, from the single result decoder, and stalls the slave side meanwhile.
// Reset clears held bytes and drops any pending result.
// When the receiver stalls, the output register holds and one completed
// batch waits behind it; further bytes are refused until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_codepoint_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_string
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [20:0] codepoint, [23:21] bytes_used
  output logic             m_axis_tuser,   // invalid
  output logic             m_axis_tlast    // last_of_run
);

  batch_t      batch_w;
  logic        batch_ready_w;
  logic [20:0] cp_w;
  logic [2:0]  used_w;

  u8d_assemble u_assemble (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (s_axis_tvalid),
    .byte_i        (s_axis_tdata),
    .end_i         (s_axis_tlast),
    .byte_ready_o  (s_axis_tready),
    .batch_o       (batch_w),
    .batch_ready_i (batch_ready_w)
  );

  u8d_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .batch_i       (batch_w),
    .batch_ready_o (batch_ready_w),
    .res_valid_o   (m_axis_tvalid),
    .res_cp_o      (cp_w),
    .res_invalid_o (m_axis_tuser),
    .res_used_o    (used_w),
    .res_last_o    (m_axis_tlast),
    .res_ready_i   (m_axis_tready)
  );

  assign m_axis_tdata = {used_w, cp_w};

endmodule

`default_nettype wire
